/* rtl/core/lcsg_pkg.sv */
// Shared types, constants and the sine table generator for the linear chirp generator.
// No dependencies; used by lcsg_sine_rom and linear_chirp_sample_generator_unit.
package lcsg_pkg;

  // Configuration port
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_INDEX_W   = 2;
  localparam int SMP_COUNT_W   = 25;  // width of the sample_count register

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PHASE_START  = 2'd0,
    CFG_STEP_START   = 2'd1,
    CFG_STEP_DELTA   = 2'd2,
    CFG_SAMPLE_COUNT = 2'd3
  } cfg_reg_t;

  // Sine table construction, Q30 fixed point
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Read request into the quarter-wave ROM
  typedef struct packed {
    logic        en;
    logic [13:0] addr;  // upper bits unused below the largest table
  } rom_req_t;

  // sin(x), x in Q30 within [0, pi/2], Horner form of the Taylor series
  function automatic longint unsigned sin_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint unsigned d;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    for (int k = 0; k < 5; k++) begin
      d = (x2 * t) >> 30;
      case (k)
        0:       d = d / 110;
        1:       d = d / 72;
        2:       d = d / 42;
        3:       d = d / 20;
        default: d = d / 6;
      endcase
      t = (d >= Q30_ONE) ? 64'd0 : Q30_ONE - d;
    end
    return (x * t) >> 30;
  endfunction

  // Magnitude of table entry a, scaled to 2^(sample_bits-1)-1, rounded half up
  function automatic longint unsigned sine_entry(input int unsigned a,
                                                 input int          addr_bits,
                                                 input int          sample_bits);
    longint unsigned x;
    longint unsigned s;
    longint unsigned fs;
    longint unsigned v;
    fs = (64'd1 << (sample_bits - 1)) - 64'd1;
    x  = ((64'd2 * longint'(a) + 64'd1) * HALF_PI_Q30) >> (addr_bits + 1);
    s  = sin_q30(x);
    v  = (s * fs + (Q30_ONE >> 1)) >> 30;
    if (v > fs) begin
      v = fs;
    end
    return v;
  endfunction

endpackage

/* rtl/core/lcsg_sine_rom.sv */
// Quarter-wave sine magnitude ROM with registered read.
// Contents built at elaboration from lcsg_pkg::sine_entry.
module lcsg_sine_rom #(
  parameter int ADDR_BITS   = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                    clk,
  input  lcsg_pkg::rom_req_t      req,
  output logic [SAMPLE_BITS-2:0]  rd_data_r
);

  localparam int TBL_N = 1 << ADDR_BITS;
  localparam int MAG_W = SAMPLE_BITS - 1;

  logic [MAG_W-1:0] lut [TBL_N];

  for (genvar a = 0; a < TBL_N; a++) begin : g_lut
    localparam longint unsigned V = lcsg_pkg::sine_entry(a, ADDR_BITS, SAMPLE_BITS);
    assign lut[a] = MAG_W'(V);
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      rd_data_r <= lut[req.addr[ADDR_BITS-1:0]];
    end
  end

endmodule

/* rtl/core/linear_chirp_sample_generator_unit.sv */
// Linear chirp sample generator: second-order phase recurrence and quarter-wave sine ROM.
// Input passes stage 1, the ROM read stage and the output stage before out_tvalid.
// Throughput: 1 item per cycle unless out_tready stalls. The ROM's read is registered.
// Reset (rst_n, synchronous, active low): empties the pipeline, zeroes the accumulators,
// clears the start flag and sets the registers to their defaults (sample_count = 1).
// Depends on lcsg_pkg and lcsg_sine_rom.
module linear_chirp_sample_generator_unit #(
  parameter int PHASE_BITS      = 32,
  parameter int TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS     = 16,
  parameter int COUNT_BITS      = 24
) (
  input  logic clk,
  input  logic rst_n,

  // Input stream: one transaction requests one sample
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [0] restart, [7:1] zero fill (ignored)

  // Result stream
  output logic                                            out_tvalid,
  input  logic                                            out_tready,
  // [SAMPLE_BITS-1:0] sample, next COUNT_BITS sample_index, rest zero fill
  output logic [((SAMPLE_BITS+COUNT_BITS+7)/8)*8-1:0]    out_tdata,
  output logic                                            out_tlast,  // last sample of sweep

  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcsg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lcsg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int OUT_DATA_W = ((SAMPLE_BITS + COUNT_BITS + 7) / 8) * 8;
  localparam int MAG_W      = SAMPLE_BITS - 1;
  // Wide enough for both sample_count and COUNT_BITS+1
  localparam int CNT_EXT_W  = (COUNT_BITS + 1 > lcsg_pkg::SMP_COUNT_W) ?
                              COUNT_BITS + 1 : lcsg_pkg::SMP_COUNT_W;

  // ------------------------------------------------------------------
  // Configuration registers. Writes are always taken.
  // ------------------------------------------------------------------
  logic [PHASE_BITS-1:0]               phase_start_r;
  logic [PHASE_BITS-1:0]               step_start_r;
  logic [PHASE_BITS-1:0]               step_delta_r;
  logic [lcsg_pkg::SMP_COUNT_W-1:0]    sample_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_start_r  <= '0;
      step_start_r   <= '0;
      step_delta_r   <= '0;
      sample_count_r <= lcsg_pkg::SMP_COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (lcsg_pkg::cfg_reg_t'(cfg_index))
        lcsg_pkg::CFG_PHASE_START:  phase_start_r  <= PHASE_BITS'(cfg_data);
        lcsg_pkg::CFG_STEP_START:   step_start_r   <= PHASE_BITS'(cfg_data);
        lcsg_pkg::CFG_STEP_DELTA:   step_delta_r   <= PHASE_BITS'(cfg_data);
        lcsg_pkg::CFG_SAMPLE_COUNT: sample_count_r <= cfg_data[lcsg_pkg::SMP_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Pipeline handshake: each stage loads when it is empty or drains.
  // ------------------------------------------------------------------
  logic v1_r, v2_r, out_valid_r;
  logic s2_rdy, s3_rdy, in_fire;

  assign s3_rdy    = !out_valid_r || out_tready;
  assign s2_rdy    = !v2_r || s3_rdy;
  assign in_tready = !v1_r || s2_rdy;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        v1_r <= in_tvalid;
      end
      if (s2_rdy) begin
        v2_r <= v1_r;
      end
      if (s3_rdy) begin
        out_valid_r <= v2_r;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: phase recurrence and sweep counter, updated per transaction.
  // A restart, the first item after reset, or the item after a last
  // sample reloads the start values.
  // ------------------------------------------------------------------
  logic [PHASE_BITS-1:0] phase_acc_r, phase_acc_nxt;
  logic [PHASE_BITS-1:0] step_acc_r, step_acc_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  started_r, started_nxt;

  logic                  load_c, last_c;
  logic [PHASE_BITS-1:0] cur_phase, cur_step;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic [CNT_EXT_W-1:0]  cnt_plus1, eff_count;

  always_comb begin
    load_c    = in_tdata[0] || !started_r;
    cur_phase = load_c ? phase_start_r : phase_acc_r;
    cur_step  = load_c ? step_start_r  : step_acc_r;
    cur_cnt   = load_c ? '0            : cnt_r;

    // Zero count acts as one; counts beyond the counter range saturate,
    // which the all-ones check covers.
    cnt_plus1 = CNT_EXT_W'(cur_cnt) + CNT_EXT_W'(1);
    eff_count = (sample_count_r == '0) ? CNT_EXT_W'(1) : CNT_EXT_W'(sample_count_r);
    last_c    = (cnt_plus1 >= eff_count) || (&cur_cnt);

    phase_acc_nxt = cur_phase + cur_step;
    step_acc_nxt  = cur_step + step_delta_r;
    cnt_nxt       = last_c ? '0 : cur_cnt + COUNT_BITS'(1);
    started_nxt   = !last_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      step_acc_r  <= '0;
      cnt_r       <= '0;
      started_r   <= 1'b0;
    end else if (in_fire) begin
      phase_acc_r <= phase_acc_nxt;
      step_acc_r  <= step_acc_nxt;
      cnt_r       <= cnt_nxt;
      started_r   <= started_nxt;
    end
  end

  // Quadrant fold: odd quadrants mirror the address, upper half negates.
  logic [TABLE_ADDR_BITS-1:0] addr1_r;
  logic                       neg1_r, last1_r;
  logic [COUNT_BITS-1:0]      idx1_r;
  logic [TABLE_ADDR_BITS-1:0] raw_addr;

  assign raw_addr = cur_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr1_r <= cur_phase[PHASE_BITS-2] ? ~raw_addr : raw_addr;
      neg1_r  <= cur_phase[PHASE_BITS-1];
      idx1_r  <= cur_cnt;
      last1_r <= last_c;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: ROM read
  // ------------------------------------------------------------------
  lcsg_pkg::rom_req_t       rom_req;
  logic [MAG_W-1:0]         rom_mag;
  logic                     neg2_r, last2_r;
  logic [COUNT_BITS-1:0]    idx2_r;

  always_comb begin
    rom_req      = '0;
    rom_req.en   = s2_rdy && v1_r;
    rom_req.addr = 14'(addr1_r);
  end

  lcsg_sine_rom #(
    .ADDR_BITS   (TABLE_ADDR_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rom (
    .clk       (clk),
    .req       (rom_req),
    .rd_data_r (rom_mag)
  );

  always_ff @(posedge clk) begin
    if (s2_rdy && v1_r) begin
      neg2_r  <= neg1_r;
      idx2_r  <= idx1_r;
      last2_r <= last1_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: sign and output register
  // ------------------------------------------------------------------
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [COUNT_BITS-1:0]  idx3_r;
  logic                   last3_r;

  assign sample_nxt = neg2_r ? -{1'b0, rom_mag} : {1'b0, rom_mag};

  always_ff @(posedge clk) begin
    if (s3_rdy && v2_r) begin
      sample_r <= sample_nxt;
      idx3_r   <= idx2_r;
      last3_r  <= last2_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({idx3_r, sample_r});
  assign out_tlast  = last3_r;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  // A result only appears after the ROM stage held an item.
  a_out_from_rom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v2_r))
    else $error("result valid without ROM stage item");

  // Table never reaches the most negative code.
  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (sample_r != {1'b1, {MAG_W{1'b0}}}))
    else $error("sample outside symmetric range");

  // Within a sweep the counter advances by one per transaction.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !last_c) |=> (cnt_r == $past(cur_cnt) + COUNT_BITS'(1)) && started_r)
    else $error("sweep counter did not advance");

  // After the last sample the next transaction reloads the start values.
  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && last_c) |=> !started_r && (cnt_r == '0))
    else $error("sweep did not wrap after last sample");

endmodule

/* tb/tb_linear_chirp_sample_generator_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for linear_chirp_sample_generator_unit: directed table, then random sweeps.
// Depends on lcsg_pkg (register index enum) and the generator RTL; holds its own chirp predictor.

module tb_linear_chirp_sample_generator_unit;

  localparam int OUT_W           = ((16 + 24 + 7) / 8) * 8;
  localparam int PIPE_LATENCY    = 2;
  localparam int SINE_ENTRIES    = 1024;
  localparam longint unsigned Q30_UNIT   = 64'd1 << 30;
  localparam longint unsigned QUARTER_PI2 = 64'd1686629713;  // pi/2 in Q30
  localparam longint unsigned SWEEP_MAX  = 64'd1 << 24;
  localparam int unsigned TAYLOR_DIV [5] = '{110, 72, 42, 20, 6};
  localparam int IDLE_PCT        = 38;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 5000;     // cycles without any transaction
  localparam int RANDOM_ITEMS    = 1280;
  localparam int MAX_REPORTS     = 40;
  localparam int N_DIRECTED      = 34;

  // Short local names for the register indexes
  localparam lcsg_pkg::cfg_reg_t SEL_PHASE = lcsg_pkg::CFG_PHASE_START;
  localparam lcsg_pkg::cfg_reg_t SEL_STEP  = lcsg_pkg::CFG_STEP_START;
  localparam lcsg_pkg::cfg_reg_t SEL_DELTA = lcsg_pkg::CFG_STEP_DELTA;
  localparam lcsg_pkg::cfg_reg_t SEL_COUNT = lcsg_pkg::CFG_SAMPLE_COUNT;

  typedef enum {ROW_CONFIG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    logic signed [15:0] amp;
    logic [23:0]        pos;
    logic               is_last;
  } chirp_sample_t;

  // Directed row: config rows write value to sel, sample rows send value[0] as restart
  typedef struct {
    row_kind_t          kind;
    lcsg_pkg::cfg_reg_t sel;
    logic [31:0]        value;
    bit                 typed;
    chirp_sample_t      want;
  } stim_row_t;

  typedef struct {
    bit            typed;
    chirp_sample_t want;
  } typed_slot_t;

  logic clk;
  logic rst_n = 1'b0;

  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata   = 8'd0;   // [0] restart, [7:1] zero fill
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;           // [15:0] sample, [39:16] sample_index
  logic               out_tlast;            // last sample of sweep
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  lcsg_pkg::cfg_reg_t cfg_index  = lcsg_pkg::CFG_PHASE_START;
  logic [31:0]        cfg_data   = 32'd0;

  linear_chirp_sample_generator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Chirp predictor: shadow registers plus the second-order phase recurrence
  // ---------------------------------------------------------------------------
  logic [15:0] sine_mag [SINE_ENTRIES];

  logic [31:0] reg_phase_start  = 32'd0;
  logic [31:0] reg_step_start   = 32'd0;
  logic [31:0] reg_step_delta   = 32'd0;
  logic [24:0] reg_sample_count = 25'd1;

  logic [31:0] acc_phase  = 32'd0;
  logic [31:0] acc_step   = 32'd0;
  logic [23:0] sweep_pos  = 24'd0;
  bit          sweep_live = 1'b0;

  chirp_sample_t expected_samples [$];
  typed_slot_t   typed_slots [$];

  int  mismatch_count  = 0;
  int  samples_checked = 0;
  int  sweep_ends      = 0;
  int  restarts_taken  = 0;
  int  reg_writes      = 0;
  int  src_idle_pct    = IDLE_PCT;
  int  sink_idle_pct   = IDLE_PCT;
  bit  hold_off_req    = 1'b0;

  // Taylor series of sin in Horner form, Q30 in and out; each product truncated
  function automatic longint unsigned taylor_sin_q30(longint unsigned x);
    longint unsigned xsq;
    longint unsigned term;
    longint unsigned part;
    xsq  = (x * x) >> 30;
    term = Q30_UNIT;
    for (int k = 0; k < 5; k++) begin
      part = ((xsq * term) >> 30) / TAYLOR_DIV[k];
      term = (part >= Q30_UNIT) ? 64'd0 : Q30_UNIT - part;
    end
    return (x * term) >> 30;
  endfunction

  // Quarter-wave magnitudes at the bin centers, scaled to 32767 with round half up
  initial begin
    longint unsigned x;
    longint unsigned mag;
    for (int a = 0; a < SINE_ENTRIES; a++) begin
      x   = ((64'd2 * a + 64'd1) * QUARTER_PI2) >> 11;
      mag = (taylor_sin_q30(x) * 64'd32767 + (Q30_UNIT >> 1)) >> 30;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      sine_mag[a] = mag[15:0];
    end
  end

  // Top two phase bits pick the quadrant, odd quadrants mirror, upper half negates
  function automatic logic signed [15:0] sine_of_phase(logic [31:0] ph);
    logic [9:0] addr;
    addr = ph[30] ? ~ph[29:20] : ph[29:20];
    return ph[31] ? -$signed(sine_mag[addr]) : $signed(sine_mag[addr]);
  endfunction

  // One sample of the sweep; reloads the start values on restart or after a last sample
  function automatic chirp_sample_t advance_chirp(bit restart);
    chirp_sample_t   res;
    longint unsigned span;
    if (restart || !sweep_live) begin
      acc_phase  = reg_phase_start;
      acc_step   = reg_step_start;
      sweep_pos  = 24'd0;
      sweep_live = 1'b1;
    end
    span = reg_sample_count;          // compared live, not latched at sweep start
    if (span == 0) begin
      span = 1;
    end
    if (span > SWEEP_MAX) begin
      span = SWEEP_MAX;
    end
    res.amp     = sine_of_phase(acc_phase);
    res.pos     = sweep_pos;
    res.is_last = ({40'd0, sweep_pos} + 64'd1) >= span;
    acc_phase   = acc_phase + acc_step;
    acc_step    = acc_step + reg_step_delta;
    if (res.is_last) begin
      sweep_pos  = 24'd0;
      sweep_live = 1'b0;
    end else begin
      sweep_pos = sweep_pos + 24'd1;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $time, what);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: config, input and result transactions, all sampled at the rising edge.
  // One block keeps the order of shadow update, prediction and check fixed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    chirp_sample_t predicted;
    chirp_sample_t want;
    typed_slot_t   slot;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          lcsg_pkg::CFG_PHASE_START:  reg_phase_start  = cfg_data;
          lcsg_pkg::CFG_STEP_START:   reg_step_start   = cfg_data;
          lcsg_pkg::CFG_STEP_DELTA:   reg_step_delta   = cfg_data;
          lcsg_pkg::CFG_SAMPLE_COUNT: reg_sample_count = cfg_data[24:0];
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        predicted = advance_chirp(in_tdata[0]);
        if (in_tdata[0]) begin
          restarts_taken++;
        end
        slot = '{typed: 1'b0, want: predicted};
        if (typed_slots.size() != 0) begin
          slot = typed_slots.pop_front();
        end
        // Directed rows with a typed-in result are checked against that value instead
        expected_samples.insert(expected_samples.size(), slot.typed ? slot.want : predicted);
      end

      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected sample tdata=%h tlast=%b", out_tdata, out_tlast));
        end else begin
          want = expected_samples.pop_front();
          samples_checked++;
          if (out_tdata[15:0] !== want.amp) begin
            report_mismatch($sformatf("sample %0d: got %0d want %0d",
                                      samples_checked, $signed(out_tdata[15:0]), want.amp));
          end
          if (out_tdata[39:16] !== want.pos) begin
            report_mismatch($sformatf("sample %0d: index got %0d want %0d",
                                      samples_checked, out_tdata[39:16], want.pos));
          end
          if (out_tlast !== want.is_last) begin
            report_mismatch($sformatf("sample %0d: tlast got %b want %b",
                                      samples_checked, out_tlast, want.is_last));
          end
          if (want.is_last) begin
            sweep_ends++;
          end
        end
      end
    end
  end

  // Watchdog: ends the run as failed once config, input and result transactions all stop
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no transaction for %0d cycles, %0d samples outstanding",
             STALL_LIMIT, expected_samples.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random back-pressure, or a long hold-off on request
  initial begin : sink_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers (change on the falling edge)
  // ---------------------------------------------------------------------------
  task automatic send_sample(bit restart, bit typed, chirp_sample_t want);
    typed_slot_t slot;
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    slot.typed = typed;
    slot.want  = want;
    typed_slots.insert(typed_slots.size(), slot);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, restart};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
  endtask

  task automatic write_register(lcsg_pkg::cfg_reg_t sel, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits at falling edges, after the monitor has settled, until nothing is outstanding
  task automatic wait_until_drained(int extra);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_samples.size() != 0) begin
      @(negedge clk);
    end
    repeat (extra) @(negedge clk);
  endtask

  // New sweep settings; some registers are left alone so old values carry over
  task automatic random_settings();
    logic [31:0] count_word;
    case ($urandom_range(9))
      0:       count_word = 32'd0;
      1:       count_word = 32'd1;
      2:       count_word = $urandom;                 // usually far beyond 2^24
      3:       count_word = 32'h01FF_FFFF;
      default: count_word = $urandom_range(60, 2);
    endcase
    if ($urandom_range(3) != 0) begin
      write_register(SEL_PHASE, $urandom);
    end
    if ($urandom_range(3) != 0) begin
      write_register(SEL_STEP, $urandom_range(1) ? $urandom : ($urandom >> 6));
    end
    if ($urandom_range(3) != 0) begin
      write_register(SEL_DELTA, $urandom_range(1) ? $urandom : ($urandom >> 12));
    end
    write_register(SEL_COUNT, count_word);
  endtask

  // Directed table. Typed results: full-scale quadrant peaks with zero phase steps.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b0, '{16'sd0, 24'd0, 1'b0}},  // first after reset
    '{ROW_SAMPLE, SEL_PHASE, 32'd1,         1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_CONFIG, SEL_PHASE, 32'h4000_0000, 1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_CONFIG, SEL_COUNT, 32'd4,         1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b1, '{16'sd32767, 24'd0, 1'b0}},
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b1, '{16'sd32767, 24'd1, 1'b0}},
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b1, '{16'sd32767, 24'd2, 1'b0}},
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b1, '{16'sd32767, 24'd3, 1'b1}},
    '{ROW_CONFIG, SEL_PHASE, 32'hC000_0000, 1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b1, '{-16'sd32767, 24'd0, 1'b0}},  // wrap
    '{ROW_SAMPLE, SEL_PHASE, 32'd1,         1'b1, '{-16'sd32767, 24'd0, 1'b0}},  // restart
    '{ROW_CONFIG, SEL_PHASE, 32'hFFFF_FFFF, 1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_CONFIG, SEL_STEP,  32'hFFFF_FFFF, 1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_CONFIG, SEL_DELTA, 32'hFFFF_FFFF, 1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_CONFIG, SEL_COUNT, 32'd0,         1'b0, '{16'sd0, 24'd0, 1'b0}},  // zero count
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b0, '{16'sd0, 24'd0, 1'b0}},  // mid-sweep
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_SAMPLE, SEL_PHASE, 32'd1,         1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_CONFIG, SEL_COUNT, 32'hFE00_0002, 1'b0, '{16'sd0, 24'd0, 1'b0}},  // upper bits
    '{ROW_CONFIG, SEL_STEP,  32'h0010_0000, 1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_CONFIG, SEL_DELTA, 32'h0000_0400, 1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_CONFIG, SEL_COUNT, 32'h0100_0000, 1'b0, '{16'sd0, 24'd0, 1'b0}},  // 2^24
    '{ROW_SAMPLE, SEL_PHASE, 32'd1,         1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_CONFIG, SEL_COUNT, 32'h01FF_FFFF, 1'b0, '{16'sd0, 24'd0, 1'b0}},  // saturates
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_CONFIG, SEL_COUNT, 32'd3,         1'b0, '{16'sd0, 24'd0, 1'b0}},  // below pos
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b0, '{16'sd0, 24'd0, 1'b0}},
    '{ROW_SAMPLE, SEL_PHASE, 32'd0,         1'b0, '{16'sd0, 24'd0, 1'b0}}
  };

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int sent;
    int batch;
    int restart_pct;
    chirp_sample_t blank;
    sent  = 0;
    blank = '{16'sd0, 24'd0, 1'b0};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part; each register write waits for the pipeline to empty first
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (directed_rows[r].kind == ROW_CONFIG) begin
        wait_until_drained(PIPE_LATENCY + 2);
        write_register(directed_rows[r].sel, directed_rows[r].value);
      end else begin
        send_sample(directed_rows[r].value[0], directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // Random sweeps. Phase 2 runs with no idling at all, phase 4 holds off the
    // result side so the pipeline backs up into in_tready, phase 6 pauses the
    // input mid-batch until every result is back.
    for (int ph = 0; sent < RANDOM_ITEMS; ph++) begin
      wait_until_drained(PIPE_LATENCY + 2);
      random_settings();
      src_idle_pct  = (ph == 2 || ph == 4) ? 0 : IDLE_PCT;
      sink_idle_pct = (ph == 2) ? 0 : IDLE_PCT;
      restart_pct   = (ph % 5 == 3) ? 30 : 3;    // mostly clean sweeps, some restart noise
      batch         = (ph == 2) ? 200 : $urandom_range(120, 40);
      if (ph == 4) begin
        hold_off_req = 1'b1;
      end
      for (int k = 0; k < batch; k++) begin
        if (ph == 6 && k == batch / 2) begin
          wait_until_drained(0);
        end
        send_sample($urandom_range(99) < restart_pct, 1'b0, blank);
        sent++;
      end
    end

    src_idle_pct = IDLE_PCT;
    wait_until_drained(PIPE_LATENCY + 10);

    $display("Checked %0d samples: %0d sweep ends, %0d restarts, %0d register writes",
             samples_checked, sweep_ends, restarts_taken, reg_writes);
    $display("Settings included zero, saturated and live-changed sample counts");
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
